@@ rtl/clpm_pkg.sv @@
// Package: shared types, codes and helpers of the card list parser and matcher.
package clpm_pkg;

  localparam int unsigned MaxLineDefault  = 24;
  localparam int unsigned MaxIdBytesDef   = 10;
  localparam int unsigned MinLine         = 10;
  localparam int unsigned LineCntW        = 5;
  localparam int unsigned ByteIdxW        = 4;
  localparam int unsigned CfgIdxW         = 2;
  localparam int unsigned CfgDataW        = 64;
  localparam int unsigned FifoDepth       = 4;
  localparam int unsigned FifoPtrW        = 2;
  localparam int unsigned FifoCntW        = 3;

  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharColon   = 8'h3A;
  localparam logic [4:0] NoBadHex    = 5'd31;
  localparam logic [4:0] BadSize     = 5'd31;

  typedef enum logic [1:0] {
    OP_CHAR    = 2'd0,
    OP_END     = 2'd1,
    OP_RESTART = 2'd2
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUERY_SIZE  = 2'd0,
    CFG_QUERY_UPPER = 2'd1,
    CFG_QUERY_LOWER = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_UNDER_10 = 3'd3,
    ST_NO_COLON = 3'd4,
    ST_BAD_SIZE = 3'd5,
    ST_SHORT    = 3'd6,
    ST_NON_HEX  = 3'd7
  } status_e;

  typedef enum logic {
    KIND_LINE    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [3:0]  card_size;
    logic [15:0] id_upper;
    logic [63:0] id_lower;
    logic        found;
    logic        last_result;
  } res_t;

  // Hex digit value 0..15, or 16 for anything that is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    return v;
  endfunction

  function automatic res_t verdict(input logic found);
    res_t r;
    r = '0;
    r.kind        = KIND_VERDICT;
    r.found       = found;
    r.last_result = 1'b1;
    return r;
  endfunction

endpackage

@@ rtl/clpm_if.sv @@
// Interfaces: input character channel and result channel.
interface clpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] character;

  modport source (output valid, output opcode, output character, input ready);
  modport sink (input valid, input opcode, input character, output ready);
endinterface

interface clpm_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status;
  logic [3:0]  card_size;
  logic [15:0] id_upper;
  logic [63:0] id_lower;
  logic        found;
  logic        last_result;

  modport source (output valid, output kind, output status, output card_size,
                  output id_upper, output id_lower, output found, output last_result,
                  input ready);
  modport sink (input valid, input kind, input status, input card_size,
                input id_upper, input id_lower, input found, input last_result,
                output ready);
endinterface

@@ rtl/card_list_parse_and_match.sv @@
// Top level: card list parser and matcher with input and result channels.
//
// Usage: characters of an allowed-card list enter on in_i, one beat each, with an
// opcode (character, end of data, restart search). While the search runs, each
// newline yields a per-line result beat on out_o; a line that ends the search (match,
// bad or empty line) is followed by a verdict beat. End of data yields the verdict,
// after judging a pending line. The query ID is set through the write port (cfg_we_i,
// cfg_idx_i, cfg_data_i); the user must do so while the block is idle (unchecked).
// Results of a beat are written into the queue at the edge that accepts it and reach
// out_o from its head. Throughput: one input beat per cycle while the queue has room;
// the line state updates in one pass at the accept edge, and results drain through a
// four-entry queue. An item with two results needs an output beat for each, so a long
// run of them paces input at the output rate.
// Reset: line state, search flags and query registers clear; the queue empties.
// Stall: with out_o.ready low the queue fills and in_i.ready drops once fewer than
// two free entries remain; no result is lost or repeated.
module card_list_parse_and_match #(
  parameter int unsigned MAX_LINE     = clpm_pkg::MaxLineDefault,
  parameter int unsigned MAX_ID_BYTES = clpm_pkg::MaxIdBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [clpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [clpm_pkg::CfgDataW-1:0] cfg_data_i,
  clpm_in_if.sink                       in_i,
  clpm_out_if.source                    out_o
);
  import clpm_pkg::*;

  logic [1:0] push_n;
  res_t       res0, res1, head;
  logic       room;
  logic       acc;

  // Accept only when the queue can take both results an item may cause.
  assign in_i.ready = room;
  assign acc        = in_i.valid && room;

  clpm_line_parser #(
    .MAX_LINE     (MAX_LINE),
    .MAX_ID_BYTES (MAX_ID_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .opcode_i    (in_i.opcode),
    .character_i (in_i.character),
    .push_n_o    (push_n),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  clpm_out_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .res0_i   (res0),
    .res1_i   (res1),
    .pop_i    (out_o.ready),
    .room_o   (room),
    .valid_o  (out_o.valid),
    .data_o   (head)
  );

  // Drive the result beat from the queue head.
  assign out_o.kind        = head.kind;
  assign out_o.status      = head.status;
  assign out_o.card_size   = head.card_size;
  assign out_o.id_upper    = head.id_upper;
  assign out_o.id_lower    = head.id_lower;
  assign out_o.found       = head.found;
  assign out_o.last_result = head.last_result;

endmodule

@@ rtl/clpm_line_parser.sv @@
// Line parser: per-character line state, line judging, query compare, search flags.
module clpm_line_parser #(
  parameter int unsigned MAX_LINE     = clpm_pkg::MaxLineDefault,
  parameter int unsigned MAX_ID_BYTES = clpm_pkg::MaxIdBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [clpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [clpm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          acc_i,
  input  logic [1:0]                    opcode_i,
  input  logic [7:0]                    character_i,
  output logic [1:0]                    push_n_o,
  output clpm_pkg::res_t                res0_o,
  output clpm_pkg::res_t                res1_o
);
  import clpm_pkg::*;

  logic [LineCntW-1:0] line_cnt_q, line_cnt_d;
  logic                overlong_q, overlong_d;
  logic [4:0]          size_q, size_d;
  logic                colon_q, colon_d;
  logic [4:0]          bad_hex_q, bad_hex_d;
  logic [3:0]          nibble_q, nibble_d;
  logic [7:0]          id_q [MAX_ID_BYTES];
  logic [7:0]          id_d [MAX_ID_BYTES];
  logic                over_q, over_d;
  logic                found_q, found_d;
  logic [3:0]          qsize_q;
  logic [15:0]         qup_q;
  logic [63:0]         qlow_q;

  logic [4:0]   hv;
  logic [6:0]   need_len;
  logic         size_ok;
  status_e      st;
  logic [79:0]  idv;
  logic [79:0]  qv;
  logic         mismatch;
  logic         match;
  res_t         line_res;

  assign hv       = hex_value(character_i);
  assign need_len = 7'({size_q, 1'b0}) + 7'd2;
  assign size_ok  = (size_q == 5'd4 || size_q == 5'd7 || size_q == 5'd10) &&
                    (size_q <= 5'(MAX_ID_BYTES));
  assign qv       = {qup_q, qlow_q};

  // Judge the pending line in the documented check order.
  always_comb begin
    priority if (overlong_q)                       st = ST_TOO_LONG;
    else if (line_cnt_q == '0)                     st = ST_EMPTY;
    else if (line_cnt_q < LineCntW'(MinLine))      st = ST_UNDER_10;
    else if (!colon_q)                             st = ST_NO_COLON;
    else if (!size_ok)                             st = ST_BAD_SIZE;
    else if (7'(line_cnt_q) < need_len)            st = ST_SHORT;
    else if (7'(bad_hex_q) < need_len)             st = ST_NON_HEX;
    else                                           st = ST_OK;
  end

  always_comb begin
    idv      = '0;
    mismatch = 1'b0;
    for (int i = 0; i < MAX_ID_BYTES; i++) begin
      if (5'(i) < size_q) begin
        idv[79-8*i -: 8] = id_q[i];
        if (id_q[i] != qv[79-8*i -: 8]) mismatch = 1'b1;
      end
    end
  end

  assign match = (st == ST_OK) && ({1'b0, qsize_q} == size_q) && (size_q != '0) && !mismatch;

  always_comb begin
    line_res             = '0;
    line_res.kind        = KIND_LINE;
    line_res.status      = st;
    line_res.found       = match;
    if (st == ST_OK) begin
      line_res.card_size = size_q[3:0];
      line_res.id_upper  = idv[79:64];
      line_res.id_lower  = idv[63:0];
    end
  end

  always_comb begin
    logic [4:0]          k;
    logic [ByteIdxW-1:0] idx;
    line_cnt_d = line_cnt_q;
    overlong_d = overlong_q;
    size_d     = size_q;
    colon_d    = colon_q;
    bad_hex_d  = bad_hex_q;
    nibble_d   = nibble_q;
    id_d       = id_q;
    over_d     = over_q;
    found_d    = found_q;
    push_n_o   = 2'd0;
    res0_o     = line_res;
    res1_o     = verdict(found_q | match);
    k          = line_cnt_q - 5'd2;
    idx        = k[4:1];
    if (acc_i) begin
      unique case (opcode_e'(opcode_i))
        OP_CHAR: begin
          if (!over_q) begin
            if (character_i != CharNewline) begin
              if (line_cnt_q >= LineCntW'(MAX_LINE)) begin
                overlong_d = 1'b1;
              end else begin
                line_cnt_d = line_cnt_q + 5'd1;
                if (line_cnt_q == 5'd0) begin
                  size_d = hv[4] ? BadSize : hv;
                end else if (line_cnt_q == 5'd1) begin
                  colon_d = (character_i == CharColon);
                end else if (hv[4]) begin
                  if (bad_hex_q == NoBadHex) bad_hex_d = line_cnt_q;
                end else if (!k[0]) begin
                  nibble_d = hv[3:0];
                end else begin
                  for (int i = 0; i < MAX_ID_BYTES; i++) begin
                    if (idx == ByteIdxW'(i)) id_d[i] = {nibble_q, hv[3:0]};
                  end
                end
              end
            end else begin
              // Close the line; a bad line or a match ends the search.
              over_d     = (st != ST_OK) || match;
              found_d    = found_q | match;
              line_cnt_d = '0;
              overlong_d = 1'b0;
              size_d     = '0;
              colon_d    = 1'b0;
              bad_hex_d  = NoBadHex;
              if ((st != ST_OK) || match) begin
                push_n_o = 2'd2;
              end else begin
                res0_o.last_result = 1'b1;
                push_n_o = 2'd1;
              end
            end
          end
        end
        OP_END: begin
          over_d     = 1'b1;
          line_cnt_d = '0;
          overlong_d = 1'b0;
          size_d     = '0;
          colon_d    = 1'b0;
          bad_hex_d  = NoBadHex;
          if (!over_q && (line_cnt_q != '0 || overlong_q)) begin
            found_d  = found_q | match;
            push_n_o = 2'd2;
          end else begin
            res0_o   = verdict(found_q);
            push_n_o = 2'd1;
          end
        end
        OP_RESTART: begin
          over_d     = 1'b0;
          found_d    = 1'b0;
          line_cnt_d = '0;
          overlong_d = 1'b0;
          size_d     = '0;
          colon_d    = 1'b0;
          bad_hex_d  = NoBadHex;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_cnt_q <= '0;
      overlong_q <= 1'b0;
      size_q     <= '0;
      colon_q    <= 1'b0;
      bad_hex_q  <= NoBadHex;
      over_q     <= 1'b0;
      found_q    <= 1'b0;
      qsize_q    <= '0;
      qup_q      <= '0;
      qlow_q     <= '0;
    end else begin
      line_cnt_q <= line_cnt_d;
      overlong_q <= overlong_d;
      size_q     <= size_d;
      colon_q    <= colon_d;
      bad_hex_q  <= bad_hex_d;
      over_q     <= over_d;
      found_q    <= found_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_QUERY_SIZE:  qsize_q <= cfg_data_i[3:0];
          CFG_QUERY_UPPER: qup_q   <= cfg_data_i[15:0];
          CFG_QUERY_LOWER: qlow_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // ID bytes and the held nibble are always written before a good line reads them.
  always_ff @(posedge clk_i) begin
    nibble_q <= nibble_d;
    id_q     <= id_d;
  end

  a_pair_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_o == 2'd2) |-> (res0_o.kind == KIND_LINE && !res0_o.last_result &&
                            res1_o.kind == KIND_VERDICT && res1_o.last_result))
    else $error("two-result beat pair malformed");

  a_match_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_o != 2'd0 && res0_o.kind == KIND_LINE && res0_o.found) |->
      (res0_o.status == ST_OK && res0_o.card_size == qsize_q && qsize_q != '0))
    else $error("line match without equal nonzero size");

  a_match_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_o != 2'd0 && res0_o.kind == KIND_LINE && res0_o.found) |=> (over_q && found_q))
    else $error("match did not end the search");

endmodule

@@ rtl/clpm_out_fifo.sv @@
// Result queue: takes up to two results a cycle, hands out one a cycle while pop_i is high.
module clpm_out_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     push_n_i,
  input  clpm_pkg::res_t res0_i,
  input  clpm_pkg::res_t res1_i,
  input  logic           pop_i,
  output logic           room_o,
  output logic           valid_o,
  output clpm_pkg::res_t data_o
);
  import clpm_pkg::*;

  res_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] rd_ptr_q, wr_ptr_q;
  logic [FifoCntW-1:0] count_q;
  logic                do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  // Leave space for the two results one item may bring.
  assign room_o  = (count_q <= FifoCntW'(FifoDepth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_q + FifoPtrW'(do_pop);
      wr_ptr_q <= wr_ptr_q + FifoPtrW'(push_n_i);
      count_q  <= count_q + FifoCntW'(push_n_i) - FifoCntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FifoDepth; i++) begin
      if (push_n_i != 2'd0 && wr_ptr_q == FifoPtrW'(i)) mem_q[i] <= res0_i;
      if (push_n_i == 2'd2 && FifoPtrW'(wr_ptr_q + 2'd1) == FifoPtrW'(i)) mem_q[i] <= res1_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (4'(count_q) + 4'(push_n_i) - 4'(do_pop)) <= 4'(FifoDepth))
    else $error("result queue overflow");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && push_n_i == 2'd0) |=> (count_q == $past(count_q) - 3'd1))
    else $error("pop did not drain one entry");

  a_pair_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i == 2'd2) |=> (wr_ptr_q == $past(wr_ptr_q) + 2'd2))
    else $error("paired push lost an entry");

endmodule
